### rtl/bm3_pkg.sv
// bm3_pkg: shared constants and types of the 3x3 box-mean smoother
// depends on nothing; used by bm3_if, bm3_ctrl, bm3_mean and the top level
`default_nettype none

package bm3_pkg;

    // fixed field widths of the channels
    localparam int CH_W        = 16;
    localparam int DIM_FIELD_W = 11;

    // defaults for the top-level parameters
    localparam int MAX_DIM_DEF      = 1024;
    localparam int CHANNEL_BITS_DEF = 16;

    // image size after reset
    localparam int DIM_RESET = 512;

    // divisor of the neighbourhood sum: 4, 6 or 9 pixels
    typedef enum logic [1:0] {
        DIV_BY4 = 2'd0,
        DIV_BY6 = 2'd1,
        DIV_BY9 = 2'd2
    } div_sel_t;

    // per-item control travelling from the position tracker to the mean pipe
    typedef struct packed {
        logic     has_res;    // this item completes one result
        logic     top_ok;     // top row of its column lies inside the image
        logic     use_left;   // left column counts toward the result
        logic     use_right;  // right column counts toward the result
        div_sel_t div_sel;
        logic     last;       // result is the final pixel of the image
    } item_ctl_t;

endpackage

`default_nettype wire

### rtl/bm3_if.sv
// bm3 channel interfaces: pixel input, smoothed result output, size register write
// depends on bm3_pkg for the field widths
`default_nettype none

interface bm3_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [bm3_pkg::CH_W-1:0]  red;
    logic [bm3_pkg::CH_W-1:0]  green;
    logic [bm3_pkg::CH_W-1:0]  blue;

    modport source (output valid, action, red, green, blue, input ready);
    modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface bm3_res_if;
    logic                      valid;
    logic                      ready;
    logic [bm3_pkg::CH_W-1:0]  out_red;
    logic [bm3_pkg::CH_W-1:0]  out_green;
    logic [bm3_pkg::CH_W-1:0]  out_blue;
    logic                      frame_last;

    modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface bm3_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bm3_pkg::DIM_FIELD_W-1:0]  image_dim;

    modport source (output valid, image_dim, input ready);
    modport sink   (input valid, image_dim, output ready);
endinterface

`default_nettype wire

### rtl/bm3_ram.sv
// bm3_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module bm3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/bm3_ctrl.sv
// bm3_ctrl: image size register, raster position of the next item, and the
// first pipeline stage holding each accepted item; depends on bm3_pkg
`default_nettype none

module bm3_ctrl #(
    parameter int MAX_DIM      = bm3_pkg::MAX_DIM_DEF,
    parameter int CHANNEL_BITS = bm3_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [bm3_pkg::DIM_FIELD_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    input  wire logic                              in_action,
    input  wire logic [3*CHANNEL_BITS-1:0]         in_pix,
    input  wire logic                              advance,
    output      logic                              rd_en,
    output      logic [$clog2(MAX_DIM)-1:0]        rd_addr,
    output      logic                              s1_valid,
    output      bm3_pkg::item_ctl_t                s1_ctl,
    output      logic [$clog2(MAX_DIM)-1:0]        s1_addr,
    output      logic [3*CHANNEL_BITS-1:0]         s1_pix
);

    localparam int COL_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int ROW_W    = $clog2(MAX_DIM + 2);
    localparam int PIX_W    = 3 * CHANNEL_BITS;
    localparam int DIM_INIT = (bm3_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : bm3_pkg::DIM_RESET;

    logic [DIM_W-1:0]   dim_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               s1_valid_reg;
    bm3_pkg::item_ctl_t s1_ctl_reg;
    logic [COL_W-1:0]   s1_addr_reg;
    logic [PIX_W-1:0]   s1_pix_reg;

    logic               accept;
    logic               flushing;
    logic               keep;
    logic               col_first;
    logic               col_wrap;
    logic               rows3;
    logic               cols3;
    logic [ROW_W-1:0]   dim_x;
    logic [ROW_W-1:0]   col_x;
    logic [ROW_W-1:0]   col_plus;
    bm3_pkg::item_ctl_t ctl_next;

    assign accept    = in_valid && advance;
    assign dim_x     = ROW_W'(dim_reg);
    assign col_x     = ROW_W'(col_reg);
    assign col_plus  = col_x + ROW_W'(1);
    assign flushing  = (row_reg >= dim_x);
    // a flush tick is dropped until every pixel of the image is in
    assign keep      = !(in_action && !flushing);
    assign col_first = (col_reg == '0);
    assign col_wrap  = (col_plus >= dim_x);

    always_comb
    begin
        ctl_next = '0;
        if (col_first)
        begin
            // result is the last pixel of the row two above
            ctl_next.has_res   = (row_reg >= ROW_W'(2));
            rows3              = (row_reg >= ROW_W'(3)) && (row_reg <= dim_x);
            cols3              = 1'b0;
            ctl_next.use_left  = 1'b1;
            ctl_next.use_right = 1'b0;
        end
        else
        begin
            ctl_next.has_res   = (row_reg >= ROW_W'(1));
            rows3              = (row_reg >= ROW_W'(2)) && (row_reg < dim_x);
            cols3              = (col_x >= ROW_W'(2));
            ctl_next.use_left  = cols3;
            ctl_next.use_right = 1'b1;
        end
        ctl_next.top_ok = (row_reg >= ROW_W'(2));
        ctl_next.last   = col_first && (row_reg == dim_x + ROW_W'(1));
        if (rows3 && cols3)
        begin
            ctl_next.div_sel = bm3_pkg::DIV_BY9;
        end
        else if (rows3 || cols3)
        begin
            ctl_next.div_sel = bm3_pkg::DIV_BY6;
        end
        else
        begin
            ctl_next.div_sel = bm3_pkg::DIV_BY4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_W'(DIM_INIT);
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_data < bm3_pkg::DIM_FIELD_W'(2))
            begin
                dim_reg <= DIM_W'(2);
            end
            else if (32'(cfg_data) > 32'(MAX_DIM))
            begin
                dim_reg <= DIM_W'(MAX_DIM);
            end
            else
            begin
                dim_reg <= DIM_W'(cfg_data);
            end
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept && keep)
        begin
            if (ctl_next.last)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (col_wrap)
            begin
                row_reg <= row_reg + ROW_W'(1);
                col_reg <= '0;
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg  <= ctl_next;
            s1_addr_reg <= col_reg;
            // flush rows bring zeros as the bottom row
            s1_pix_reg  <= flushing ? '0 : in_pix;
        end
    end

    assign rd_en    = accept;
    assign rd_addr  = col_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_pix   = s1_pix_reg;

endmodule

`default_nettype wire

### rtl/bm3_mean.sv
// bm3_mean: column-sum window, neighbourhood sum and reciprocal divide,
// ending in the result register; depends on bm3_pkg
`default_nettype none

module bm3_mean #(
    parameter int CHANNEL_BITS = bm3_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          s1_valid,
    input  wire bm3_pkg::item_ctl_t            s1_ctl,
    input  wire logic [3*CHANNEL_BITS-1:0]     top_pix,
    input  wire logic [3*CHANNEL_BITS-1:0]     mid_pix,
    input  wire logic [3*CHANNEL_BITS-1:0]     bot_pix,
    output      logic                          out_valid,
    output      logic [bm3_pkg::CH_W-1:0]      out_red,
    output      logic [bm3_pkg::CH_W-1:0]      out_green,
    output      logic [bm3_pkg::CH_W-1:0]      out_blue,
    output      logic                          out_last
);

    localparam int CB     = CHANNEL_BITS;
    localparam int CS_W   = CB + 2;
    localparam int SUM_W  = CB + 4;
    localparam int SH     = SUM_W + 4;
    localparam int MUL_W  = SH;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] RECIP6 = MUL_W'(((64'd1 << SH) + 64'd5) / 64'd6);
    localparam logic [MUL_W-1:0] RECIP9 = MUL_W'(((64'd1 << SH) + 64'd8) / 64'd9);

    // window of column sums: [column 0 oldest .. 2 newest][channel]
    logic [CS_W-1:0]    win_reg [3][3];
    logic [CS_W-1:0]    col_new [3];
    logic               s2_valid_reg;
    bm3_pkg::item_ctl_t s2_ctl_reg;
    logic               s3_valid_reg;
    logic [SUM_W-1:0]   s3_sum_reg [3];
    bm3_pkg::div_sel_t  s3_div_reg;
    logic               s3_last_reg;
    logic               out_valid_reg;
    logic [CB-1:0]      out_mean_reg [3];
    logic               out_last_reg;
    logic [SUM_W-1:0]   sum_next [3];

    // truncated mean by shift or reciprocal multiply; exact for s < 2**SUM_W
    function automatic logic [CB-1:0] box_div(input logic [SUM_W-1:0] s,
                                              input bm3_pkg::div_sel_t sel);
        logic [MUL_W-1:0]  recip;
        logic [PROD_W-1:0] prod;
        recip = (sel == bm3_pkg::DIV_BY6) ? RECIP6 : RECIP9;
        prod  = PROD_W'(s) * PROD_W'(recip);
        case (sel)
            bm3_pkg::DIV_BY4: box_div = s[2 +: CB];
            default:          box_div = prod[SH +: CB];
        endcase
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            col_new[k] = (s1_ctl.top_ok ? CS_W'(top_pix[k*CB +: CB]) : CS_W'(0))
                       + CS_W'(mid_pix[k*CB +: CB]) + CS_W'(bot_pix[k*CB +: CB]);
            sum_next[k] = SUM_W'(win_reg[1][k])
                        + (s2_ctl_reg.use_left  ? SUM_W'(win_reg[0][k]) : SUM_W'(0))
                        + (s2_ctl_reg.use_right ? SUM_W'(win_reg[2][k]) : SUM_W'(0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid && s1_ctl.has_res;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s1_valid)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[0][k] <= win_reg[1][k];
                    win_reg[1][k] <= win_reg[2][k];
                    win_reg[2][k] <= col_new[k];
                end
            end
            s2_ctl_reg <= s1_ctl;
            for (int k = 0; k < 3; k++)
            begin
                s3_sum_reg[k]   <= sum_next[k];
                out_mean_reg[k] <= box_div(s3_sum_reg[k], s3_div_reg);
            end
            s3_div_reg   <= s2_ctl_reg.div_sel;
            s3_last_reg  <= s2_ctl_reg.last;
            out_last_reg <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = bm3_pkg::CH_W'(out_mean_reg[0]);
    assign out_green = bm3_pkg::CH_W'(out_mean_reg[1]);
    assign out_blue  = bm3_pkg::CH_W'(out_mean_reg[2]);
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

### rtl/box_mean_3x3_image_smoother.sv
// box_mean_3x3_image_smoother: top level of the 3x3 box-mean rgb smoother
// depends on bm3_pkg, bm3_if, bm3_ram, bm3_ctrl and bm3_mean
//
// usage:
//   pixels carries one item per pixel in raster order (action 0), or a flush
//   tick (action 1). results carries the smoothed pixels; frame_last marks
//   the last one of the image. cfg writes image_dim (clamped to 2..MAX_DIM)
//   and restarts the image; write it only while the block is idle.
//   the result for a pixel comes out with the item that brings the pixel
//   one row plus one column later; after the last pixel, image_dim + 1 flush
//   ticks push out the remaining results. flush ticks sent while pixels are
//   still expected are dropped.
//   one item is accepted every cycle unless the receiver stalls; the item that
//   completes a result passes the input stage, line store read and column window,
//   neighbourhood sum and reciprocal-multiply divide into the output register.
//   a stalled receiver freezes the whole pipe and drops pixels.ready until
//   the output register is taken. reset clears the position, empties the
//   pipe and sets image_dim to 512; no clearing pass is needed.
`default_nettype none

module box_mean_3x3_image_smoother #(
    parameter int MAX_DIM      = bm3_pkg::MAX_DIM_DEF,
    parameter int CHANNEL_BITS = bm3_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bm3_pix_if.sink    pixels,
    bm3_res_if.source  results,
    bm3_cfg_if.sink    cfg
);

    localparam int COL_W = $clog2(MAX_DIM);
    localparam int PIX_W = 3 * CHANNEL_BITS;

    logic               advance;
    logic               res_valid;
    logic               rd_en;
    logic [COL_W-1:0]   rd_addr;
    logic               s1_valid;
    bm3_pkg::item_ctl_t s1_ctl;
    logic [COL_W-1:0]   s1_addr;
    logic [PIX_W-1:0]   s1_pix;
    logic [PIX_W-1:0]   in_pix;
    logic [PIX_W-1:0]   near_rd;
    logic [PIX_W-1:0]   far_rd;
    logic               line_we;

    assign advance       = !res_valid || results.ready;
    assign pixels.ready  = advance;
    assign cfg.ready     = 1'b1;
    assign results.valid = res_valid;
    assign in_pix        = {pixels.blue[CHANNEL_BITS-1:0], pixels.green[CHANNEL_BITS-1:0],
                            pixels.red[CHANNEL_BITS-1:0]};
    // line stores are updated as an item leaves the input stage
    assign line_we       = advance && s1_valid;

    bm3_ctrl #(
        .MAX_DIM      (MAX_DIM),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.image_dim),
        .in_valid  (pixels.valid),
        .in_action (pixels.action),
        .in_pix    (in_pix),
        .advance   (advance),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_addr   (s1_addr),
        .s1_pix    (s1_pix)
    );

    // previous row
    bm3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_DIM)
    ) u_near (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_addr),
        .wdata (s1_pix),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (near_rd)
    );

    // row before that
    bm3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_DIM)
    ) u_far (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_addr),
        .wdata (near_rd),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (far_rd)
    );

    bm3_mean #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .top_pix   (far_rd),
        .mid_pix   (near_rd),
        .bot_pix   (s1_pix),
        .out_valid (res_valid),
        .out_red   (results.out_red),
        .out_green (results.out_green),
        .out_blue  (results.out_blue),
        .out_last  (results.frame_last)
    );

endmodule

`default_nettype wire

### tb/bm3_tb_pkg.sv
`timescale 1ns / 100ps
// bm3_tb_pkg: item codes and the pixel type shared by the smoother testbench
// depends on bm3_pkg for the channel width
package bm3_tb_pkg;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    typedef struct packed {
        logic [bm3_pkg::CH_W-1:0] red;
        logic [bm3_pkg::CH_W-1:0] green;
        logic [bm3_pkg::CH_W-1:0] blue;
    } rgb_t;

endpackage

### tb/bm3_checker.sv
`timescale 1ns / 100ps
// bm3_checker: tracks image position, line stores and window of the smoother,
// predicts every smoothed pixel and compares it with the result channel
// depends on bm3_pkg, bm3_tb_pkg and the bm3 channel interfaces
module bm3_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    bm3_pix_if        pixels,
    bm3_res_if        results,
    bm3_cfg_if        cfg,
    output int        mismatches,
    output int        outstanding
);
    import bm3_pkg::*;
    import bm3_tb_pkg::*;

    localparam int unsigned LINE_LEN  = MAX_DIM_DEF;

    typedef struct packed {
        rgb_t px;
        logic frame_last;
    } smoothed_t;

    rgb_t        near_line [LINE_LEN];
    rgb_t        far_line  [LINE_LEN];
    rgb_t        win       [3][3];      // [column: oldest .. newest][row: top .. bottom]
    int unsigned dim;
    int unsigned row;
    int unsigned col;
    int unsigned given;
    smoothed_t   smoothed_q [$];

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("[%0t] smoother %s: got %0h, want %0h", $time, field, got, want);
        mismatches++;
    endtask

    function automatic logic [CH_W-1:0] scale(int unsigned s, div_sel_t sel);
        case (sel)
            DIV_BY4: return CH_W'(s >> 2);
            DIV_BY6: return CH_W'(s / 6);
            default: return CH_W'(s / 9);
        endcase
    endfunction

    // mean around window column cs for image pixel (r, c)
    function automatic rgb_t box_mean(int unsigned cs, int unsigned r, int unsigned c);
        int unsigned s_red;
        int unsigned s_green;
        int unsigned s_blue;
        int unsigned span;
        bit          up_ok;
        bit          down_ok;
        bit          left_ok;
        bit          right_ok;
        div_sel_t    sel;
        rgb_t        m;
        up_ok    = (r >= 1);
        down_ok  = (r + 1 < dim);
        left_ok  = (c >= 1);
        // at a row end the right neighbour is not in the window yet
        right_ok = (c + 1 < dim) && (cs == 1);
        s_red    = 0;
        s_green  = 0;
        s_blue   = 0;
        for (int ri = 0; ri < 3; ri++)
        begin
            if ((ri == 0 && !up_ok) || (ri == 2 && !down_ok))
                continue;
            for (int ci = 0; ci < 3; ci++)
            begin
                if ((ci == 0 && !left_ok) || (ci == 2 && !right_ok))
                    continue;
                s_red   += win[cs + ci - 1][ri].red;
                s_green += win[cs + ci - 1][ri].green;
                s_blue  += win[cs + ci - 1][ri].blue;
            end
        end
        span = (1 + up_ok + down_ok) * (1 + left_ok + right_ok);
        case (span)
            4:       sel = DIV_BY4;
            6:       sel = DIV_BY6;
            default: sel = DIV_BY9;
        endcase
        m.red   = scale(s_red, sel);
        m.green = scale(s_green, sel);
        m.blue  = scale(s_blue, sel);
        return m;
    endfunction

    task automatic take_item(action_t act, rgb_t px);
        int unsigned ir;
        int unsigned ic;
        bit          flushing;
        bit          got;
        rgb_t        top_px;
        rgb_t        mid_px;
        rgb_t        bot_px;
        smoothed_t   res;
        ir       = row;
        ic       = col;
        flushing = (ir >= dim);
        got      = 1'b0;
        res      = '0;
        // flush ticks before the image is complete are dropped
        if (act == ACT_FLUSH && !flushing)
            return;
        if (ic >= dim)
            ic = 0;
        bot_px = flushing ? rgb_t'('0) : px;
        top_px = far_line[ic];
        mid_px = near_line[ic];
        // first column of a row completes the last pixel of the row two above
        if (ic == 0 && ir >= 2)
        begin
            res.px = box_mean(2, ir - 2, dim - 1);
            got    = 1'b1;
        end
        for (int k = 0; k < 3; k++)
        begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
        end
        win[2][0]     = top_px;
        win[2][1]     = mid_px;
        win[2][2]     = bot_px;
        far_line[ic]  = mid_px;
        near_line[ic] = bot_px;
        if (ic >= 1 && ir >= 1)
        begin
            res.px = box_mean(1, ir - 1, ic - 1);
            got    = 1'b1;
        end
        ic++;
        if (ic >= dim)
        begin
            ic = 0;
            ir++;
        end
        row = ir;
        col = ic;
        if (got)
        begin
            res.frame_last = (given + 1 >= dim * dim);
            if (res.frame_last)
            begin
                row   = 0;
                col   = 0;
                given = 0;
            end
            else
                given++;
            smoothed_q.push_back(res);
        end
    endtask

    task automatic check_result();
        smoothed_t want;
        if (smoothed_q.size() == 0)
        begin
            report_mismatch("item with none pending, out_red", results.out_red, 0);
            return;
        end
        want = smoothed_q.pop_front();
        if (results.out_red !== want.px.red)
            report_mismatch("out_red", results.out_red, want.px.red);
        if (results.out_green !== want.px.green)
            report_mismatch("out_green", results.out_green, want.px.green);
        if (results.out_blue !== want.px.blue)
            report_mismatch("out_blue", results.out_blue, want.px.blue);
        if (results.frame_last !== want.frame_last)
            report_mismatch("frame_last", results.frame_last, want.frame_last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_LEN; i++)
            begin
                near_line[i] = '0;
                far_line[i]  = '0;
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            dim   = DIM_RESET;
            row   = 0;
            col   = 0;
            given = 0;
            smoothed_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (results.valid && results.ready)
                check_result();
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.image_dim < 2)
                    dim = 2;
                else if (cfg.image_dim > LINE_LEN)
                    dim = LINE_LEN;
                else
                    dim = cfg.image_dim;
                row   = 0;
                col   = 0;
                given = 0;
            end
            if (pixels.valid && pixels.ready)
                take_item(action_t'(pixels.action),
                          {pixels.red, pixels.green, pixels.blue});
            outstanding = smoothed_q.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for the 3x3 box-mean smoother
// depends on bm3_pkg, bm3_if, bm3_tb_pkg, bm3_checker and the smoother rtl
module tb_top;
    import bm3_pkg::*;
    import bm3_tb_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int ITEM_TARGET     = 1900;
    localparam int CALM_ITEMS      = 250;
    localparam int BIG_FRAME_ITEMS = 24 * 24 + 24 + 1;

    typedef enum int {
        PX_RANDOM,
        PX_FULL_SCALE
    } px_style_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bm3_pix_if pix_if ();
    bm3_res_if res_if ();
    bm3_cfg_if cfg_if ();

    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    int          gap_pct = 20;
    int          stall_pct = 20;
    int unsigned items_sent;

    box_mean_3x3_image_smoother dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    bm3_checker smooth_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pix_if),
        .results     (res_if),
        .cfg         (cfg_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    function automatic rgb_t rand_px(px_style_t style);
        rgb_t p;
        p.red   = CH_W'($urandom);
        p.green = CH_W'($urandom);
        p.blue  = CH_W'($urandom);
        if (style == PX_FULL_SCALE)
            p = '1;
        else
            case ($urandom_range(0, 7))
                0:       p = '0;
                1:       p = '1;
                2:       p = p | {3{16'hFF00}};
                default: ;
            endcase
        return p;
    endfunction

    task automatic push_item(action_t act, rgb_t px);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        pix_if.valid  <= 1'b1;
        pix_if.action <= act;
        pix_if.red    <= px.red;
        pix_if.green  <= px.green;
        pix_if.blue   <= px.blue;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
    endtask

    // all predicted pixels out, then let ignored items clear the pipe
    task automatic settle();
        pix_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_dim(logic [DIM_FIELD_W-1:0] v);
        settle();
        cfg_if.valid     <= 1'b1;
        cfg_if.image_dim <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // one image: d*d pixels then d+1 flush ticks; cut stops early
    task automatic run_frame(int unsigned d, px_style_t style, int unsigned cut,
                             int unsigned noise_pct);
        int unsigned total;
        total = (cut != 0) ? cut : d * d + d + 1;
        for (int unsigned k = 0; k < total; k++)
        begin
            if (k < d * d)
            begin
                // dropped flush tick while pixels are still due
                if (noise_pct != 0 && $urandom_range(1, 100) <= noise_pct)
                    push_item(ACT_FLUSH, rand_px(PX_RANDOM));
                push_item(ACT_PIXEL, rand_px(style));
            end
            else if (noise_pct != 0 && $urandom_range(1, 100) <= noise_pct)
                push_item(ACT_PIXEL, rand_px(PX_RANDOM));
            else
                push_item(ACT_FLUSH, rand_px(PX_RANDOM));
            items_sent++;
        end
    endtask

    initial
    begin
        int unsigned d;
        int unsigned last_dim;
        int unsigned cut;
        bit          frame_whole;
        bit          calm;
        pix_if.valid     <= 1'b0;
        pix_if.action    <= ACT_PIXEL;
        pix_if.red       <= '0;
        pix_if.green     <= '0;
        pix_if.blue      <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.image_dim <= '0;
        items_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // size after reset, just past the first results
        run_frame(DIM_RESET, PX_RANDOM, DIM_RESET + 4, 0);
        // clamp from below, dropped flushes and pixels acting as flush ticks
        write_dim(11'd0);
        run_frame(2, PX_RANDOM, 0, 100);
        write_dim(11'd1);
        run_frame(2, PX_RANDOM, 2, 0);
        write_dim(11'd3);
        run_frame(3, PX_FULL_SCALE, 0, 0);
        // largest size uses the line stores over their whole depth
        write_dim(11'd1024);
        run_frame(1024, PX_RANDOM, 1028, 0);
        write_dim(11'h7FF);
        run_frame(1024, PX_RANDOM, 3, 0);

        frame_whole = 1'b0;
        last_dim    = 0;
        while (items_sent < ITEM_TARGET)
        begin
            calm = (items_sent + CALM_ITEMS >= ITEM_TARGET);
            if (calm)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            // back-to-back images at the same size need no write
            if (!frame_whole || $urandom_range(0, 2) != 0)
            begin
                d = ($urandom_range(0, 4) == 0 && items_sent + BIG_FRAME_ITEMS < ITEM_TARGET)
                    ? $urandom_range(9, 24) : $urandom_range(2, 8);
                write_dim(DIM_FIELD_W'(d));
            end
            else
                d = last_dim;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, d * d + d) : 0;
            run_frame(d, PX_RANDOM, cut, ($urandom_range(0, 1) == 0) ? 0 : 4);
            frame_whole = (cut == 0);
            last_dim    = d;
        end
        settle();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
